[design/mpfp_pkg.sv]
package mpfp_pkg;

  // Default depth of the capture counter window.
  localparam int unsigned CaptureDepthDefault = 256;

  // Header byte of a QoS 0 PUBLISH frame.
  localparam logic [7:0] HdrPublish = 8'h30;

  // Payload widths.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 7;
  localparam int unsigned LenW   = 7;

  // Widths of the packed master-side stream.
  localparam int unsigned MTdataW = 32;
  localparam int unsigned MTuserW = 2;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_REM_LEN   = 3'd1,
    PH_TLEN_HIGH = 3'd2,
    PH_TLEN_LOW  = 3'd3,
    PH_TOPIC     = 3'd4,
    PH_PAYLOAD   = 3'd5
  } phase_e;

  // Kind of a result.
  typedef enum logic [1:0] {
    KIND_TOPIC   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  // One result of the parser.
  typedef struct packed {
    kind_e              item_kind;
    logic [ByteW-1:0]   data_byte;
    logic [IndexW-1:0]  byte_index;
    logic               frame_done;
    logic [LenW-1:0]    topic_length;
    logic [LenW-1:0]    payload_length;
  } result_t;

endpackage

[design/mpfp_parser.sv]
module mpfp_parser #(
  parameter int unsigned CAPTURE_DEPTH = mpfp_pkg::CaptureDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [mpfp_pkg::ByteW-1:0] rx_byte_i,
  input  logic                       parse_enable_i,
  output logic                       res_valid_o,
  output mpfp_pkg::result_t          res_o
);

  localparam int unsigned CapW = $clog2(CAPTURE_DEPTH + 1);

  mpfp_pkg::phase_e      phase_q, phase_d;
  logic [6:0]            bytes_left_q, bytes_left_d;
  logic [7:0]            topic_size_q, topic_size_d;
  logic [6:0]            topic_seen_q, topic_seen_d;
  logic [6:0]            payload_seen_q, payload_seen_d;
  logic [CapW-1:0]       capture_count_q, capture_count_d;

  logic       cap_full;
  logic       run;
  logic [6:0] bytes_left_dec;
  logic [6:0] topic_seen_inc;
  logic [6:0] payload_seen_inc;
  logic [7:0] tlen_low;
  logic       tlen_bad;
  logic       topic_last;
  logic       rem_len_bad;

  // Shared arithmetic for the current byte.
  assign cap_full         = capture_count_q >= CapW'(CAPTURE_DEPTH);
  assign run              = accept_i && !cap_full && parse_enable_i;
  assign bytes_left_dec   = bytes_left_q - 7'd1;
  assign topic_seen_inc   = topic_seen_q + 7'd1;
  assign payload_seen_inc = payload_seen_q + 7'd1;
  assign tlen_low         = (topic_size_q != 8'd255) ? rx_byte_i : 8'd255;
  assign tlen_bad         = tlen_low > {1'b0, bytes_left_q};
  assign topic_last       = {1'b0, topic_seen_inc} == topic_size_q;
  assign rem_len_bad      = rx_byte_i[7] || (rx_byte_i < 8'd2);

  // Next state.
  always_comb begin
    phase_d         = phase_q;
    bytes_left_d    = bytes_left_q;
    topic_size_d    = topic_size_q;
    topic_seen_d    = topic_seen_q;
    payload_seen_d  = payload_seen_q;
    capture_count_d = capture_count_q;
    if (accept_i && !cap_full) begin
      capture_count_d = capture_count_q + CapW'(1);
    end
    if (run) begin
      case (phase_q)
        mpfp_pkg::PH_REM_LEN: begin
          if (rem_len_bad) begin
            phase_d         = mpfp_pkg::PH_IDLE;
            capture_count_d = '0;
          end else begin
            bytes_left_d   = rx_byte_i[6:0] - 7'd2;
            topic_size_d   = '0;
            topic_seen_d   = '0;
            payload_seen_d = '0;
            phase_d        = mpfp_pkg::PH_TLEN_HIGH;
          end
        end
        mpfp_pkg::PH_TLEN_HIGH: begin
          topic_size_d = (rx_byte_i != 8'd0) ? 8'd255 : 8'd0;
          phase_d      = mpfp_pkg::PH_TLEN_LOW;
        end
        mpfp_pkg::PH_TLEN_LOW: begin
          if (tlen_bad) begin
            topic_size_d    = '0;
            phase_d         = mpfp_pkg::PH_IDLE;
            capture_count_d = '0;
          end else begin
            topic_size_d = tlen_low;
            if (tlen_low == 8'd0) begin
              if (bytes_left_q == 7'd0) begin
                phase_d         = mpfp_pkg::PH_IDLE;
                capture_count_d = '0;
              end else begin
                phase_d = mpfp_pkg::PH_PAYLOAD;
              end
            end else begin
              phase_d = mpfp_pkg::PH_TOPIC;
            end
          end
        end
        mpfp_pkg::PH_TOPIC: begin
          bytes_left_d = bytes_left_dec;
          topic_seen_d = topic_seen_inc;
          if (topic_last) begin
            if (bytes_left_dec == 7'd0) begin
              phase_d         = mpfp_pkg::PH_IDLE;
              capture_count_d = '0;
            end else begin
              phase_d = mpfp_pkg::PH_PAYLOAD;
            end
          end
        end
        mpfp_pkg::PH_PAYLOAD: begin
          bytes_left_d   = bytes_left_dec;
          payload_seen_d = payload_seen_inc;
          if (bytes_left_dec == 7'd0) begin
            phase_d         = mpfp_pkg::PH_IDLE;
            capture_count_d = '0;
          end
        end
        default: begin
          // Waiting for a header; anything else restarts the capture window.
          if (rx_byte_i == mpfp_pkg::HdrPublish) begin
            phase_d = mpfp_pkg::PH_REM_LEN;
          end else begin
            phase_d         = mpfp_pkg::PH_IDLE;
            capture_count_d = '0;
          end
        end
      endcase
    end
  end

  // Result for the current byte.
  always_comb begin
    res_valid_o          = 1'b0;
    res_o.item_kind      = mpfp_pkg::KIND_TOPIC;
    res_o.data_byte      = rx_byte_i;
    res_o.byte_index     = '0;
    res_o.frame_done     = 1'b0;
    res_o.topic_length   = topic_size_q[6:0];
    res_o.payload_length = '0;
    if (run) begin
      case (phase_q)
        mpfp_pkg::PH_TLEN_LOW: begin
          // Frame with neither topic nor payload bytes.
          if (!tlen_bad && (tlen_low == 8'd0) && (bytes_left_q == 7'd0)) begin
            res_valid_o        = 1'b1;
            res_o.item_kind    = mpfp_pkg::KIND_END;
            res_o.data_byte    = '0;
            res_o.frame_done   = 1'b1;
            res_o.topic_length = '0;
          end
        end
        mpfp_pkg::PH_TOPIC: begin
          res_valid_o      = 1'b1;
          res_o.byte_index = topic_seen_q;
          res_o.frame_done = topic_last && (bytes_left_dec == 7'd0);
        end
        mpfp_pkg::PH_PAYLOAD: begin
          res_valid_o          = 1'b1;
          res_o.item_kind      = mpfp_pkg::KIND_PAYLOAD;
          res_o.byte_index     = payload_seen_q;
          res_o.frame_done     = bytes_left_dec == 7'd0;
          res_o.payload_length = payload_seen_inc;
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= mpfp_pkg::PH_IDLE;
      bytes_left_q    <= '0;
      topic_size_q    <= '0;
      topic_seen_q    <= '0;
      payload_seen_q  <= '0;
      capture_count_q <= '0;
    end else begin
      phase_q         <= phase_d;
      bytes_left_q    <= bytes_left_d;
      topic_size_q    <= topic_size_d;
      topic_seen_q    <= topic_seen_d;
      payload_seen_q  <= payload_seen_d;
      capture_count_q <= capture_count_d;
    end
  end

endmodule

[design/mpfp_out_buf.sv]
module mpfp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mpfp_pkg::result_t push_data_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output mpfp_pkg::result_t data_o
);

  mpfp_pkg::result_t slot_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              pop;

  // Two entries let a new request in while a finished result waits.
  assign space_o = count_q != 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = slot_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/mqtt_publish_frame_parser_core.sv]
// Results are registered in a two-entry buffer before they reach the master stream.
// Throughput: one byte per cycle while that buffer has space; the parser state updates in
// the cycle a byte is accepted; input stays open while one result waits downstream.
// Reset (rst_ni low, asynchronous) returns the parser to waiting for a header,
// clears all counters, empties the result buffer and disables parsing.
module mqtt_publish_frame_parser_core #(
  parameter int unsigned CAPTURE_DEPTH = mpfp_pkg::CaptureDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel: parse_enable.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_data_i,
  // Byte input stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
  // Result stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] data_byte, [14:8] byte_index, [21:15] topic_length,
  // [28:22] payload_length, [31:29] zero
  output logic [mpfp_pkg::MTdataW-1:0] m_axis_tdata,
  output logic [mpfp_pkg::MTuserW-1:0] m_axis_tuser,  // [1:0] item_kind
  output logic                         m_axis_tlast   // frame_done
);

  logic              parse_enable_q;
  logic              accept;
  logic              space;
  logic              res_valid;
  mpfp_pkg::result_t res;
  mpfp_pkg::result_t out_res;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      parse_enable_q <= cfg_data_i;
    end
  end

  // Input handshake.
  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  mpfp_parser #(
    .CAPTURE_DEPTH(CAPTURE_DEPTH)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (s_axis_tdata),
    .parse_enable_i(parse_enable_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  mpfp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .space_o    (space),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (out_res)
  );

  // Pack the result onto the master stream.
  assign m_axis_tdata = {3'b000, out_res.payload_length, out_res.topic_length,
                         out_res.byte_index, out_res.data_byte};
  assign m_axis_tuser = out_res.item_kind;
  assign m_axis_tlast = out_res.frame_done;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import mpfp_pkg::*;

  localparam int unsigned CaptureDepth = CaptureDepthDefault;
  localparam int unsigned ItemTarget   = 1750;
  localparam int unsigned TailItems    = 320;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SettleCycles = 4;

  // How a stimulus row is checked: by the predictor, no result, or a typed-in result.
  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_LIT
  } chk_e;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_op_e;

  typedef struct {
    row_op_e    op;
    logic [7:0] val;
    chk_e       chk;
    result_t    res;
  } row_t;

  localparam result_t NoResult = '0;
  localparam int      DirRows  = 30;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [MTdataW-1:0]  m_axis_tdata;
  logic [MTuserW-1:0]  m_axis_tuser;
  logic                m_axis_tlast;

  // Shadow copy of the parser state and the enable register.
  logic                prs_enable;
  phase_e              prs_phase;
  logic [6:0]          prs_remaining;
  logic [7:0]          prs_tsize;
  logic [6:0]          prs_tcount;
  logic [6:0]          prs_pcount;
  int unsigned         prs_captured;

  result_t             pending_results [$];
  int unsigned         mismatches;
  int unsigned         accepted_items;
  int unsigned         cycle_count;
  int                  send_burst;
  int                  recv_burst;

  // Directed frames: disabled parser, idle discard, every abort and every empty case.
  row_t dir_rows [DirRows] = '{
    '{ROW_CFG,  8'h00, CHK_NONE, NoResult},
    '{ROW_BYTE, 8'h30, CHK_NONE, NoResult},
    '{ROW_CFG,  8'h01, CHK_NONE, NoResult},
    '{ROW_BYTE, 8'h00, CHK_NONE, NoResult},
    '{ROW_BYTE, 8'h30, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h02, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h00, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h00, CHK_LIT,  '{KIND_END, 8'h00, 7'd0, 1'b1, 7'd0, 7'd0}},
    '{ROW_BYTE, 8'h30, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h80, CHK_NONE, NoResult},
    '{ROW_BYTE, 8'h30, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h01, CHK_NONE, NoResult},
    '{ROW_BYTE, 8'h30, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h02, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'hFF, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h00, CHK_NONE, NoResult},
    '{ROW_BYTE, 8'h30, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h04, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h00, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h03, CHK_NONE, NoResult},
    '{ROW_BYTE, 8'h30, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h03, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h00, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h01, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'hFF, CHK_LIT,  '{KIND_TOPIC, 8'hFF, 7'd0, 1'b1, 7'd1, 7'd0}},
    '{ROW_BYTE, 8'h30, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h03, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h00, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'h00, CHK_PRED, NoResult},
    '{ROW_BYTE, 8'hA5, CHK_LIT,  '{KIND_PAYLOAD, 8'hA5, 7'd0, 1'b1, 7'd0, 7'd1}}
  };

  mqtt_publish_frame_parser_core #(
    .CAPTURE_DEPTH(CaptureDepth)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Wait cycles before a request: mostly random, sometimes a run with no waits at all.
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Advances the shadow parser by one received byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    r = '0;
    if (prs_captured >= CaptureDepth) begin
      return 1'b0;
    end
    prs_captured++;
    if (!prs_enable) begin
      return 1'b0;
    end
    case (prs_phase)
      PH_REM_LEN: begin
        if (b >= 8'd128 || b < 8'd2) begin
          prs_phase    = PH_IDLE;
          prs_captured = 0;
          return 1'b0;
        end
        prs_remaining = 7'(b - 8'd2);
        prs_tsize     = '0;
        prs_tcount    = '0;
        prs_pcount    = '0;
        prs_phase     = PH_TLEN_HIGH;
        return 1'b0;
      end
      PH_TLEN_HIGH: begin
        // A nonzero high byte marks the topic as oversized.
        prs_tsize = (b != 8'd0) ? 8'd255 : 8'd0;
        prs_phase = PH_TLEN_LOW;
        return 1'b0;
      end
      PH_TLEN_LOW: begin
        if (prs_tsize != 8'd255) begin
          prs_tsize = b;
        end
        if (prs_tsize > {1'b0, prs_remaining}) begin
          prs_tsize    = '0;
          prs_phase    = PH_IDLE;
          prs_captured = 0;
          return 1'b0;
        end
        if (prs_tsize == 8'd0) begin
          if (prs_remaining == 7'd0) begin
            r            = '{KIND_END, 8'h00, 7'd0, 1'b1, 7'd0, 7'd0};
            prs_phase    = PH_IDLE;
            prs_captured = 0;
            return 1'b1;
          end
          prs_phase = PH_PAYLOAD;
          return 1'b0;
        end
        prs_phase = PH_TOPIC;
        return 1'b0;
      end
      PH_TOPIC: begin
        prs_remaining--;
        prs_tcount++;
        r.item_kind    = KIND_TOPIC;
        r.data_byte    = b;
        r.byte_index   = prs_tcount - 7'd1;
        r.topic_length = prs_tsize[6:0];
        if ({1'b0, prs_tcount} == prs_tsize) begin
          if (prs_remaining == 7'd0) begin
            r.frame_done = 1'b1;
            prs_phase    = PH_IDLE;
            prs_captured = 0;
          end else begin
            prs_phase = PH_PAYLOAD;
          end
        end
        return 1'b1;
      end
      PH_PAYLOAD: begin
        prs_remaining--;
        prs_pcount++;
        r.item_kind      = KIND_PAYLOAD;
        r.data_byte      = b;
        r.byte_index     = prs_pcount - 7'd1;
        r.topic_length   = prs_tsize[6:0];
        r.payload_length = prs_pcount;
        if (prs_remaining == 7'd0) begin
          r.frame_done = 1'b1;
          prs_phase    = PH_IDLE;
          prs_captured = 0;
        end
        return 1'b1;
      end
      default: begin
        if (b == HdrPublish) begin
          prs_phase = PH_REM_LEN;
        end else begin
          prs_phase    = PH_IDLE;
          prs_captured = 0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Sends one byte request and records what it should produce.
  task automatic push_byte(input logic [7:0] b, input chk_e chk, input result_t lit);
    int      gap;
    bit      has_result;
    result_t r;
    gap = draw_wait(send_burst);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    if (prs_enable && prs_captured < CaptureDepth) begin
      accepted_items++;
    end
    has_result = parse_byte(b, r);
    case (chk)
      CHK_PRED: begin
        if (has_result) begin
          pending_results.push_back(r);
        end
      end
      CHK_LIT: begin
        pending_results.push_back(lit);
      end
      default: begin
      end
    endcase
  endtask

  // Holds the input off until every outstanding result has been seen.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic en);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    prs_enable = en;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random sequence: mostly complete frames, plus truncated frames, aborts and noise.
  task automatic send_random_sequence();
    logic [7:0] seq [$];
    int         sel;
    int         rem;
    int         tlen;
    int         cut;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      if ($urandom_range(0, 9) == 0) begin
        rem = $urandom_range(100, 127);
      end else begin
        rem = $urandom_range(2, 24);
      end
      case ($urandom_range(0, 3))
        0: tlen = 0;
        1: tlen = rem - 2;
        default: tlen = $urandom_range(0, rem - 2);
      endcase
      seq.push_back(HdrPublish);
      seq.push_back(8'(rem));
      seq.push_back(8'h00);
      seq.push_back(8'(tlen));
      repeat (rem - 2) seq.push_back(8'($urandom));
      if (sel >= 69) begin
        cut = $urandom_range(1, seq.size() - 1);
        while (seq.size() > cut) void'(seq.pop_back());
      end
    end else if (sel < 83) begin
      seq.push_back(HdrPublish);
      if ($urandom_range(0, 1) == 1) begin
        seq.push_back(8'($urandom_range(0, 1)));
      end else begin
        seq.push_back(8'($urandom_range(128, 255)));
      end
    end else if (sel < 89) begin
      seq.push_back(HdrPublish);
      seq.push_back(8'($urandom_range(2, 127)));
      seq.push_back(8'($urandom_range(1, 255)));
      seq.push_back(8'($urandom));
    end else if (sel < 95) begin
      rem = $urandom_range(2, 127);
      seq.push_back(HdrPublish);
      seq.push_back(8'(rem));
      seq.push_back(8'h00);
      seq.push_back(8'($urandom_range(rem - 1, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom));
    end
    foreach (seq[i]) begin
      push_byte(seq[i], CHK_PRED, NoResult);
    end
  endtask

  // Result side: random stalls between requests.
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(recv_burst);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, tdata 0x%08h tuser %0d",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_results.pop_front();
        check_field("item_kind", m_axis_tuser, want.item_kind);
        check_field("data_byte", m_axis_tdata[7:0], want.data_byte);
        check_field("byte_index", m_axis_tdata[14:8], want.byte_index);
        check_field("frame_done", m_axis_tlast, want.frame_done);
        check_field("topic_length", m_axis_tdata[21:15], want.topic_length);
        check_field("payload_length", m_axis_tdata[28:22], want.payload_length);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    prs_enable     = 1'b0;
    prs_phase      = PH_IDLE;
    prs_remaining  = '0;
    prs_tsize      = '0;
    prs_tcount     = '0;
    prs_pcount     = '0;
    prs_captured   = 0;
    mismatches     = 0;
    accepted_items = 0;
    cycle_count    = 0;
    send_burst     = 0;
    recv_burst     = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG) begin
        wait_drained();
        write_enable(dir_rows[i].val[0]);
      end else begin
        push_byte(dir_rows[i].val, dir_rows[i].chk, dir_rows[i].res);
      end
    end

    // Random frames with occasional disabled stretches; the capture count stays
    // well below the depth so the parser never locks up here.
    while (accepted_items < ItemTarget - TailItems) begin
      if ($urandom_range(0, 39) == 0) begin
        wait_drained();
        write_enable(1'b0);
        repeat ($urandom_range(0, 12)) begin
          if (prs_captured < 100) begin
            push_byte(8'($urandom), CHK_PRED, NoResult);
          end
        end
        wait_drained();
        write_enable(1'b1);
      end
      send_random_sequence();
    end

    // Fill the capture window to 16 short of its depth while disabled, then run a frame that fills it.
    wait_drained();
    write_enable(1'b0);
    while (prs_captured < CaptureDepth - 16) begin
      push_byte(8'($urandom), CHK_PRED, NoResult);
    end
    wait_drained();
    write_enable(1'b1);
    push_byte(HdrPublish, CHK_PRED, NoResult);
    push_byte(8'd60, CHK_PRED, NoResult);
    push_byte(8'h00, CHK_PRED, NoResult);
    push_byte(8'd5, CHK_PRED, NoResult);
    repeat (70) push_byte(8'($urandom), CHK_PRED, NoResult);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
